### hw/rtl/uart_tx_rx_ring_buffers_core_defines.svh
// Assertion macros shared by the ring buffer RTL.
// Included by modules that check their own logic; depends on nothing.
`ifndef UART_TX_RX_RING_BUFFERS_CORE_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define UTRB_ASSERT_NOW(label, clock, reset, cond, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
    else $error("utrb check failed");

// Check that a condition implies a consequence in the next cycle.
`define UTRB_ASSERT_NEXT(label, clock, reset, cond, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
    else $error("utrb check failed");

`endif

### hw/rtl/utrb_pkg.sv
// Shared types and constants for the UART ring buffer block.
// Used by utrb_ctrl, utrb_dp and the top level; depends on nothing.
package utrb_pkg;

  localparam int TX_DEPTH_DEF = 128;
  localparam int RX_DEPTH_DEF = 128;
  localparam int BYTE_W       = 8;
  localparam int LEVEL_W      = 8;
  localparam int CFG_IDX_W    = 2;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_TX_EMPTY = 3'd2,
    OP_RX_BYTE = 3'd3,
    OP_TX_DONE = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_START   = 2'd0,
    CFG_TX_DRAINED = 2'd1,
    CFG_TX_IDLE    = 2'd2
  } cfg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EXEC = 2'd2
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic exec;
  } cmd_t;

endpackage

### hw/rtl/utrb_ctrl.sv
// Controller state machine for the UART ring buffer block.
// Sequences load, memory read and update; owns both handshakes. Uses utrb_pkg.
module utrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output utrb_pkg::cmd_t  cmd
);
  import utrb_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        // hold off requests during reset
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Set on update, drop when the result is taken
  always_comb begin
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### hw/rtl/utrb_dp.sv
// Datapath for the UART ring buffer block: byte memories, pointers, counts,
// notification registers and result registers. Uses utrb_pkg and the defines header.
`include "uart_tx_rx_ring_buffers_core_defines.svh"

module utrb_dp #(
  parameter int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  utrb_pkg::cmd_t                  cmd,
  input  logic [2:0]                      operation,
  input  logic [utrb_pkg::BYTE_W-1:0]     byte_in,
  input  logic                            cfg_we,
  input  logic [utrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                            cfg_data,
  output logic                            accepted,
  output logic [utrb_pkg::BYTE_W-1:0]     byte_out,
  output logic                            line_send,
  output logic                            rx_started,
  output logic                            tx_drained,
  output logic                            tx_idle,
  output logic                            rx_lost,
  output logic [utrb_pkg::LEVEL_W-1:0]    tx_level,
  output logic [utrb_pkg::LEVEL_W-1:0]    rx_level
);
  import utrb_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
  localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_CW:0]   TX_WRAP = (TX_CW + 1)'(TX_DEPTH);
  localparam logic [RX_CW:0]   RX_WRAP = (RX_CW + 1)'(RX_DEPTH);

  // Byte memories
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_rd, rx_rd;

  // Request registers
  op_t               op_q;
  logic [BYTE_W-1:0] byte_q;

  // Ring state
  logic [TX_AW-1:0] tx_head, tx_head_next;
  logic [TX_CW-1:0] tx_count, tx_count_next;
  logic [RX_AW-1:0] rx_head, rx_head_next;
  logic [RX_CW-1:0] rx_count, rx_count_next;
  logic             tx_space_armed, tx_space_armed_next;
  logic             tx_done_armed, tx_done_armed_next;

  // Notification enables
  logic notify_rx_start_on, notify_tx_drained_on, notify_tx_idle_on;

  // Addresses
  logic [TX_CW:0]   tx_wr_sum;
  logic [TX_AW-1:0] tx_wr_addr;
  logic [RX_CW:0]   rx_rd_sum;
  logic [RX_AW-1:0] rx_rd_addr;
  logic             tx_wr_en, rx_wr_en;

  // Result values
  logic              accepted_next, line_send_next, rx_started_next;
  logic              tx_drained_next, tx_idle_next, rx_lost_next;
  logic [BYTE_W-1:0] byte_out_next;

  // Updates on a full ring
  logic exec_rx_full, exec_tx_full;

  // Tail of transmit ring, oldest unread receive slot
  always_comb begin
    tx_wr_sum = {{(TX_CW + 1 - TX_AW){1'b0}}, tx_head} + {1'b0, tx_count};
    if (tx_wr_sum >= TX_WRAP) begin
      tx_wr_sum = tx_wr_sum - TX_WRAP;
    end
    tx_wr_addr = tx_wr_sum[TX_AW-1:0];
    rx_rd_sum = {{(RX_CW + 1 - RX_AW){1'b0}}, rx_head} + RX_WRAP - {1'b0, rx_count};
    if (rx_rd_sum >= RX_WRAP) begin
      rx_rd_sum = rx_rd_sum - RX_WRAP;
    end
    rx_rd_addr = rx_rd_sum[RX_AW-1:0];
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(operation);
      byte_q <= byte_in;
    end
  end

  // Transmit memory
  always_ff @(posedge clk) begin
    if (tx_wr_en) begin
      tx_mem[tx_wr_addr] <= byte_q;
    end
    if (cmd.read) begin
      tx_rd <= tx_mem[tx_head];
    end
  end

  // Receive memory
  always_ff @(posedge clk) begin
    if (rx_wr_en) begin
      rx_mem[rx_head] <= byte_q;
    end
    if (cmd.read) begin
      rx_rd <= rx_mem[rx_rd_addr];
    end
  end

  // Work out the update for the latched request
  always_comb begin
    tx_head_next        = tx_head;
    tx_count_next       = tx_count;
    rx_head_next        = rx_head;
    rx_count_next       = rx_count;
    tx_space_armed_next = tx_space_armed;
    tx_done_armed_next  = tx_done_armed;
    tx_wr_en            = 1'b0;
    rx_wr_en            = 1'b0;
    accepted_next       = 1'b0;
    byte_out_next       = '0;
    line_send_next      = 1'b0;
    rx_started_next     = 1'b0;
    tx_drained_next     = 1'b0;
    tx_idle_next        = 1'b0;
    rx_lost_next        = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (tx_count != TX_FULL) begin
          tx_wr_en      = cmd.exec;
          tx_count_next = tx_count + 1'b1;
          accepted_next = 1'b1;
        end
        tx_space_armed_next = 1'b1;
        tx_done_armed_next  = 1'b1;
      end
      OP_POP: begin
        if (rx_count != '0) begin
          byte_out_next = rx_rd;
          rx_count_next = rx_count - 1'b1;
          accepted_next = 1'b1;
        end
      end
      OP_TX_EMPTY: begin
        if (tx_space_armed) begin
          if (tx_count != '0) begin
            byte_out_next   = tx_rd;
            line_send_next  = 1'b1;
            tx_count_next   = tx_count - 1'b1;
            tx_head_next    = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
            tx_drained_next = (tx_count == TX_CW'(1)) && notify_tx_drained_on;
          end else begin
            tx_space_armed_next = 1'b0;
          end
        end
      end
      OP_RX_BYTE: begin
        rx_wr_en     = cmd.exec;
        rx_head_next = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
        if (rx_count != RX_FULL) begin
          rx_count_next = rx_count + 1'b1;
        end else begin
          rx_lost_next = 1'b1;
        end
        rx_started_next = (rx_count == '0) && notify_rx_start_on;
      end
      OP_TX_DONE: begin
        if (tx_done_armed && (tx_count == '0) && notify_tx_idle_on) begin
          tx_idle_next       = 1'b1;
          tx_done_armed_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Ring state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head              <= '0;
      tx_count             <= '0;
      rx_head              <= '0;
      rx_count             <= '0;
      tx_space_armed       <= 1'b0;
      tx_done_armed        <= 1'b0;
      notify_rx_start_on   <= 1'b1;
      notify_tx_drained_on <= 1'b1;
      notify_tx_idle_on    <= 1'b1;
    end else begin
      if (cmd.exec) begin
        tx_head        <= tx_head_next;
        tx_count       <= tx_count_next;
        rx_head        <= rx_head_next;
        rx_count       <= rx_count_next;
        tx_space_armed <= tx_space_armed_next;
        tx_done_armed  <= tx_done_armed_next;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RX_START:   notify_rx_start_on   <= cfg_data;
          CFG_TX_DRAINED: notify_tx_drained_on <= cfg_data;
          CFG_TX_IDLE:    notify_tx_idle_on    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted   <= accepted_next;
      byte_out   <= byte_out_next;
      line_send  <= line_send_next;
      rx_started <= rx_started_next;
      tx_drained <= tx_drained_next;
      tx_idle    <= tx_idle_next;
      rx_lost    <= rx_lost_next;
      tx_level   <= LEVEL_W'(tx_count_next);
      rx_level   <= LEVEL_W'(rx_count_next);
    end
  end

  // Flag an update on a full ring
  assign exec_rx_full = cmd.exec && (op_q == OP_RX_BYTE) && (rx_count == RX_FULL);
  assign exec_tx_full = cmd.exec && (op_q == OP_PUSH) && (tx_count == TX_FULL);

  `UTRB_ASSERT_NOW(a_tx_bound, clk, rst, 1'b1, tx_count <= TX_FULL)
  `UTRB_ASSERT_NOW(a_rx_bound, clk, rst, 1'b1, rx_count <= RX_FULL)
  `UTRB_ASSERT_NEXT(a_rx_sat, clk, rst, exec_rx_full, rx_count == RX_FULL && rx_lost)
  `UTRB_ASSERT_NEXT(a_tx_refuse, clk, rst, exec_tx_full, tx_count == TX_FULL && !accepted)

endmodule

### hw/rtl/uart_tx_rx_ring_buffers_core.sv
// Top level of the UART transmit/receive ring buffer block.
// Joins utrb_ctrl and utrb_dp; uses utrb_pkg.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  operation, byte_in
//   out      from block out_valid / out_stall accepted, byte_out, line_send, flags, levels
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// Each request has three steps: accept, memory read, update into the result register.
// A new request is taken only after the current one is updated; the controller holds the input
// while the registered memory read and the update of the current request run.
// The update waits while an earlier result is still held in the output register.
// Reset clears pointers, counts, arming bits and the controller; memories are not cleared.
module uart_tx_rx_ring_buffers_core #(
  parameter int TX_DEPTH = utrb_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = utrb_pkg::RX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      operation,
  input  logic [utrb_pkg::BYTE_W-1:0]     byte_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            accepted,
  output logic [utrb_pkg::BYTE_W-1:0]     byte_out,
  output logic                            line_send,
  output logic                            rx_started,
  output logic                            tx_drained,
  output logic                            tx_idle,
  output logic                            rx_lost,
  output logic [utrb_pkg::LEVEL_W-1:0]    tx_level,
  output logic [utrb_pkg::LEVEL_W-1:0]    rx_level,
  input  logic                            cfg_we,
  input  logic [utrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                            cfg_data
);
  import utrb_pkg::*;

  cmd_t cmd;

  utrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  utrb_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (operation),
    .byte_in    (byte_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accepted   (accepted),
    .byte_out   (byte_out),
    .line_send  (line_send),
    .rx_started (rx_started),
    .tx_drained (tx_drained),
    .tx_idle    (tx_idle),
    .rx_lost    (rx_lost),
    .tx_level   (tx_level),
    .rx_level   (rx_level)
  );

endmodule

### tb/uart_ring_checker.sv
// Scoreboard for the UART ring buffer block: tracks both rings and the notify bits,
// predicts the status of every request and compares it with each result.
// Depends on utrb_pkg for operation codes, register indexes and default depths.
module uart_ring_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] operation,
  input  logic [7:0] byte_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       accepted,
  input  logic [7:0] byte_out,
  input  logic       line_send,
  input  logic       rx_started,
  input  logic       tx_drained,
  input  logic       tx_idle,
  input  logic       rx_lost,
  input  logic [7:0] tx_level,
  input  logic [7:0] rx_level,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  output int         pending,
  output int         failures
);
  import utrb_pkg::*;

  localparam int TX_D = TX_DEPTH_DEF;
  localparam int RX_D = RX_DEPTH_DEF;

  typedef struct packed {
    logic       accepted;
    logic [7:0] byte_out;
    logic       line_send;
    logic       rx_started;
    logic       tx_drained;
    logic       tx_idle;
    logic       rx_lost;
    logic [7:0] tx_level;
    logic [7:0] rx_level;
  } ring_status_t;

  // Shadow copy of the rings, pointers, arming bits and notify enables
  logic [7:0]   tx_ring [TX_D];
  logic [7:0]   rx_ring [RX_D];
  int           tx_oldest;
  int           tx_fill;
  int           rx_next;
  int           rx_fill;
  logic         send_armed;
  logic         done_armed;
  logic         rx_start_on;
  logic         drained_on;
  logic         idle_on;
  ring_status_t status_due [$];

  task automatic report_mismatch(string msg);
    failures = failures + 1;
    $display("checker: %s at %0t", msg, $time);
  endtask

  // Apply one request to the shadow state and return the status it should produce
  function automatic ring_status_t predict_status(logic [2:0] op, logic [7:0] data);
    ring_status_t s;
    s = '0;
    case (op)
      OP_PUSH: begin
        if (tx_fill < TX_D) begin
          tx_ring[(tx_oldest + tx_fill) % TX_D] = data;
          tx_fill = tx_fill + 1;
          s.accepted = 1'b1;
        end
        // a refused push still arms both transmit events
        send_armed = 1'b1;
        done_armed = 1'b1;
      end
      OP_POP: begin
        if (rx_fill > 0) begin
          s.byte_out = rx_ring[(rx_next + RX_D - rx_fill) % RX_D];
          rx_fill = rx_fill - 1;
          s.accepted = 1'b1;
        end
      end
      OP_TX_EMPTY: begin
        if (send_armed) begin
          if (tx_fill > 0) begin
            s.byte_out  = tx_ring[tx_oldest];
            s.line_send = 1'b1;
            tx_fill     = tx_fill - 1;
            tx_oldest   = (tx_oldest + 1) % TX_D;
            s.tx_drained = (tx_fill == 0) && drained_on;
          end else begin
            send_armed = 1'b0;
          end
        end
      end
      OP_RX_BYTE: begin
        // overwrite the oldest byte when full; the fill level saturates
        rx_ring[rx_next] = data;
        rx_next = (rx_next + 1) % RX_D;
        if (rx_fill < RX_D) rx_fill = rx_fill + 1;
        else s.rx_lost = 1'b1;
        s.rx_started = (rx_fill == 1) && rx_start_on;
      end
      OP_TX_DONE: begin
        if (done_armed && tx_fill == 0 && idle_on) begin
          s.tx_idle  = 1'b1;
          done_armed = 1'b0;
        end
      end
      default: ;
    endcase
    s.tx_level = 8'(tx_fill);
    s.rx_level = 8'(rx_fill);
    return s;
  endfunction

  // Track register writes, check results, then record new requests
  always @(posedge clk) begin : watch
    ring_status_t got;
    ring_status_t want;
    if (rst) begin
      tx_oldest   = 0;
      tx_fill     = 0;
      rx_next     = 0;
      rx_fill     = 0;
      send_armed  = 1'b0;
      done_armed  = 1'b0;
      rx_start_on = 1'b1;
      drained_on  = 1'b1;
      idle_on     = 1'b1;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RX_START:   rx_start_on = cfg_data;
          CFG_TX_DRAINED: drained_on  = cfg_data;
          CFG_TX_IDLE:    idle_on     = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {accepted, byte_out, line_send, rx_started, tx_drained, tx_idle, rx_lost,
               tx_level, rx_level};
        if (status_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = status_due.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %0h expected %0h",
                                      got.accepted, want.accepted));
          if (got.byte_out !== want.byte_out)
            report_mismatch($sformatf("byte_out got %0h expected %0h",
                                      got.byte_out, want.byte_out));
          if (got.line_send !== want.line_send)
            report_mismatch($sformatf("line_send got %0h expected %0h",
                                      got.line_send, want.line_send));
          if (got.rx_started !== want.rx_started)
            report_mismatch($sformatf("rx_started got %0h expected %0h",
                                      got.rx_started, want.rx_started));
          if (got.tx_drained !== want.tx_drained)
            report_mismatch($sformatf("tx_drained got %0h expected %0h",
                                      got.tx_drained, want.tx_drained));
          if (got.tx_idle !== want.tx_idle)
            report_mismatch($sformatf("tx_idle got %0h expected %0h",
                                      got.tx_idle, want.tx_idle));
          if (got.rx_lost !== want.rx_lost)
            report_mismatch($sformatf("rx_lost got %0h expected %0h",
                                      got.rx_lost, want.rx_lost));
          if (got.tx_level !== want.tx_level)
            report_mismatch($sformatf("tx_level got %0d expected %0d",
                                      got.tx_level, want.tx_level));
          if (got.rx_level !== want.rx_level)
            report_mismatch($sformatf("rx_level got %0d expected %0d",
                                      got.rx_level, want.rx_level));
        end
      end
      if (in_valid && !in_stall) status_due.push_back(predict_status(operation, byte_in));
    end
    pending = status_due.size();
  end

endmodule

### tb/tb_uart_tx_rx_ring_buffers_core.sv
// Top of the UART ring buffer testbench: clock, reset, register settings and requests.
// Depends on utrb_pkg, the block under test and uart_ring_checker, which does the checking.
module tb_uart_tx_rx_ring_buffers_core;
  import utrb_pkg::*;

  localparam logic [2:0] OP_CODE_MAX = 3'd7;
  localparam int         RUN_LIMIT   = 4000000;
  localparam int         DRAIN_LIMIT = 20000;

  typedef enum int {FILL_TX, DRAIN_TX, FILL_RX, DRAIN_RX, MIXED} episode_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [2:0] operation = OP_PUSH;
  logic [7:0] byte_in   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       accepted;
  logic [7:0] byte_out;
  logic       line_send;
  logic       rx_started;
  logic       tx_drained;
  logic       tx_idle;
  logic       rx_lost;
  logic [7:0] tx_level;
  logic [7:0] rx_level;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = CFG_RX_START;
  logic       cfg_data  = 1'b0;
  int         pending;
  int         failures;

  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  uart_tx_rx_ring_buffers_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .byte_out(byte_out), .line_send(line_send),
    .rx_started(rx_started), .tx_drained(tx_drained), .tx_idle(tx_idle),
    .rx_lost(rx_lost), .tx_level(tx_level), .rx_level(rx_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  uart_ring_checker ring_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .byte_out(byte_out), .line_send(line_send),
    .rx_started(rx_started), .tx_drained(tx_drained), .tx_idle(tx_idle),
    .rx_lost(rx_lost), .tx_level(tx_level), .rx_level(rx_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side in stretches of varying density
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
        stall_left = $urandom_range(16, 200);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Send one request; open a new burst, mostly after a random gap, when the last one ran out
  task automatic issue(logic [2:0] op, logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      if ($urandom_range(0, 4) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    operation <= op;
    byte_in   <= data;
    do @(posedge clk); while (in_stall);
    burst_left = burst_left - 1;
  endtask

  // Hold off until every result is back, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three notify enables on consecutive cycles
  task automatic apply_setting(logic rx_start, logic drained, logic idle);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RX_START;
    cfg_data  <= rx_start;
    @(posedge clk);
    cfg_index <= CFG_TX_DRAINED;
    cfg_data  <= drained;
    @(posedge clk);
    cfg_index <= CFG_TX_IDLE;
    cfg_data  <= idle;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bias the operation mix toward the episode's goal, with a little noise
  function automatic logic [2:0] pick_op(episode_t kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      FILL_TX:  if (roll < 85) return OP_PUSH;
      DRAIN_TX: begin
        if (roll < 70) return OP_TX_EMPTY;
        else if (roll < 85) return OP_TX_DONE;
      end
      FILL_RX:  if (roll < 85) return OP_RX_BYTE;
      DRAIN_RX: if (roll < 75) return OP_POP;
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) return 3'($urandom_range(OP_TX_DONE + 1, OP_CODE_MAX));
    return 3'($urandom_range(OP_PUSH, OP_TX_DONE));
  endfunction

  task automatic run_episode(episode_t kind, int length);
    repeat (length) issue(pick_op(kind), 8'($urandom));
  endtask

  task automatic run_random(int quota);
    int done;
    int len;
    episode_t kind;
    done = 0;
    while (done < quota) begin
      kind = episode_t'($urandom_range(FILL_TX, MIXED));
      len  = $urandom_range(10, 120);
      if (len > quota - done) len = quota - done;
      run_episode(kind, len);
      done = done + len;
    end
  endtask

  // Stop a hung run
  initial begin
    #RUN_LIMIT;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int drain_wait;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    apply_setting(1'b1, 1'b1, 1'b1);

    // Corner cases on empty rings, disarmed transmit events and unused operation codes
    issue(OP_POP, 8'hFF);
    issue(OP_TX_EMPTY, 8'h00);
    issue(OP_TX_DONE, 8'h00);
    for (int code = OP_TX_DONE + 1; code <= OP_CODE_MAX; code++) issue(3'(code), 8'hFF);
    // Queue extremes, then check that a transmit complete with bytes queued is ignored
    issue(OP_PUSH, 8'h00);
    issue(OP_PUSH, 8'hFF);
    issue(OP_TX_DONE, 8'h00);
    // Send both bytes, then disarm on the empty queue
    issue(OP_TX_EMPTY, 8'h00);
    issue(OP_TX_EMPTY, 8'h00);
    issue(OP_TX_EMPTY, 8'h00);
    issue(OP_TX_EMPTY, 8'h00);
    // Idle report fires once, then stays disarmed
    issue(OP_TX_DONE, 8'h00);
    issue(OP_TX_DONE, 8'h00);
    // Receive start, pop in order, pop from empty
    issue(OP_RX_BYTE, 8'h00);
    issue(OP_RX_BYTE, 8'hFF);
    issue(OP_POP, 8'h00);
    issue(OP_POP, 8'h00);
    issue(OP_POP, 8'h00);
    issue(OP_RX_BYTE, 8'h5A);
    issue(OP_POP, 8'hA5);

    // Overfill both rings, then run drain episodes on them
    run_episode(FILL_TX, 190);
    run_episode(FILL_RX, 190);
    run_episode(DRAIN_TX, 120);
    run_episode(DRAIN_RX, 120);
    run_random(100);

    settle();
    apply_setting(1'b0, 1'b0, 1'b0);
    run_random(180);

    settle();
    apply_setting(1'b1, 1'b0, 1'b1);
    run_random(180);

    settle();
    apply_setting(1'b0, 1'b1, 1'b0);
    run_random(180);

    // Wait out the remaining results, then give the verdict
    in_valid <= 1'b0;
    drain_wait = 0;
    @(negedge clk);
    while (pending != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait = drain_wait + 1;
    end
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### uart_tx_rx_ring_buffers_core.f
+incdir+hw/rtl
hw/rtl/utrb_pkg.sv
hw/rtl/utrb_ctrl.sv
hw/rtl/utrb_dp.sv
hw/rtl/uart_tx_rx_ring_buffers_core.sv
tb/uart_ring_checker.sv
tb/tb_uart_tx_rx_ring_buffers_core.sv
